// File: src/cts_pkg.sv
// Shared types, constants and elaboration-time table functions for the circular setpoint block.
package cts_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ADDR_W            = 5;
  localparam int DATA_W            = 32;
  localparam int ANG_W             = 36;
  localparam int XY_W              = 34;
  localparam int MOD_STEPS         = 18;
  localparam int ANG_STAGES        = MOD_STEPS + 3;
  localparam int POSE_STAGES       = 2;

  localparam logic [31:0]        DUR_LIMIT = 32'd65536000;
  localparam logic signed [15:0] Q15_ONE   = 16'sd32767;

  // largest power-of-three term still allowed to grow by 9
  localparam longint unsigned P3_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF / 9;

  typedef enum logic [2:0] {
    REG_HUB_X        = 3'd0,
    REG_HUB_Y        = 3'd1,
    REG_HUB_Z        = 3'd2,
    REG_RADIUS       = 3'd3,
    REG_START_ANGLE  = 3'd4,
    REG_ANGULAR_RATE = 3'd5,
    REG_DURATION     = 3'd6,
    REG_FACING_MODE  = 3'd7
  } reg_idx_t;

  localparam logic [1:0] FACE_CENTER   = 2'd0;
  localparam logic [1:0] FACE_FIXED    = 2'd1;
  localparam logic [1:0] FACE_IDENTITY = 2'd2;

  typedef struct packed {
    logic signed [31:0] hub_x;
    logic signed [31:0] hub_y;
    logic signed [31:0] hub_z;
    logic [30:0]        radius;
    logic signed [19:0] start_angle;
    logic signed [19:0] angular_rate;
    logic [31:0]        duration;
    logic [1:0]         facing_mode;
  } cfg_t;

  typedef struct packed {
    logic               pose_valid;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_z;
  } pose_t;

  typedef struct packed {
    pose_t pose;
    logic  finished;
  } result_t;

  // restoring shift-and-subtract quotient for the table constants
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    int b;
    q = 64'd0;
    r = 64'd0;
    for (b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q.62 by its power series, i >= 1
  function automatic longint unsigned atan_pow2_q62(input int i);
    longint unsigned sum;
    longint unsigned term;
    int k;
    int e;
    sum = 64'd0;
    k = 0;
    e = 62 - i;
    while (e >= 0) begin
      term = udiv64(64'd1 << e, 64'(2 * k + 1));
      if (k[0]) sum = sum - term;
      else sum = sum + term;
      k = k + 1;
      e = 62 - i * (2 * k + 1);
    end
    return sum;
  endfunction

  // atan(1/3) in Q.62
  function automatic longint unsigned atan_third_q62();
    longint unsigned sum;
    longint unsigned term;
    longint unsigned p3;
    int k;
    bit done;
    sum = 64'd0;
    p3 = 64'd3;
    k = 0;
    done = 1'b0;
    while (!done) begin
      term = udiv64(udiv64(64'd1 << 62, p3), 64'(2 * k + 1));
      if (k[0]) sum = sum - term;
      else sum = sum + term;
      k = k + 1;
      if (p3 > P3_LIMIT) done = 1'b1;
      else p3 = p3 * 64'd9;
    end
    return sum;
  endfunction

  function automatic longint unsigned atan_q32(input int i);
    longint unsigned a;
    if (i == 0) a = atan_pow2_q62(1) + atan_third_q62();
    else a = atan_pow2_q62(i);
    return (a + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint unsigned pi_q32_calc();
    longint unsigned a1;
    a1 = atan_pow2_q62(1) + atan_third_q62();
    return (64'd4 * a1 + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint unsigned isqrt64(input longint unsigned v_in);
    longint unsigned v;
    longint unsigned res;
    longint unsigned b;
    v = v_in;
    res = 64'd0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 1/gain in Q.30, gain squared accumulated in Q.60 with truncating shifts
  function automatic longint unsigned kinv_q30(input int n);
    longint unsigned p;
    int i;
    p = 64'd1 << 60;
    for (i = 0; i < n; i++) p = p + (p >> (2 * i));
    return udiv64(64'd1 << 60, isqrt64(p));
  endfunction

  localparam longint unsigned PI_Q32      = pi_q32_calc();
  localparam longint unsigned TWO_PI_Q32  = 2 * PI_Q32;
  localparam longint unsigned HALF_PI_Q32 = PI_Q32 / 2;

endpackage

// File: src/cts_regs.sv
// APB register file holding the trajectory configuration.
module cts_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cts_pkg::ADDR_W-1:0] paddr,
  input  logic [cts_pkg::DATA_W-1:0] pwdata,
  output logic [cts_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output cts_pkg::cfg_t              cfg
);

  cts_pkg::cfg_t     cfg_r;
  cts_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = cts_pkg::reg_idx_t'(paddr[cts_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (idx)
        cts_pkg::REG_HUB_X:        cfg_r.hub_x        <= pwdata;
        cts_pkg::REG_HUB_Y:        cfg_r.hub_y        <= pwdata;
        cts_pkg::REG_HUB_Z:        cfg_r.hub_z        <= pwdata;
        cts_pkg::REG_RADIUS:       cfg_r.radius       <= pwdata[30:0];
        cts_pkg::REG_START_ANGLE:  cfg_r.start_angle  <= pwdata[19:0];
        cts_pkg::REG_ANGULAR_RATE: cfg_r.angular_rate <= pwdata[19:0];
        cts_pkg::REG_DURATION:     cfg_r.duration     <= pwdata;
        cts_pkg::REG_FACING_MODE:  cfg_r.facing_mode  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cts_pkg::REG_HUB_X:        prdata = cfg_r.hub_x;
      cts_pkg::REG_HUB_Y:        prdata = cfg_r.hub_y;
      cts_pkg::REG_HUB_Z:        prdata = cfg_r.hub_z;
      cts_pkg::REG_RADIUS:       prdata = {1'b0, cfg_r.radius};
      cts_pkg::REG_START_ANGLE:  prdata = {12'd0, cfg_r.start_angle};
      cts_pkg::REG_ANGULAR_RATE: prdata = {12'd0, cfg_r.angular_rate};
      cts_pkg::REG_DURATION:     prdata = cfg_r.duration;
      cts_pkg::REG_FACING_MODE:  prdata = {30'd0, cfg_r.facing_mode};
      default:                   prdata = '0;
    endcase
  end

endmodule

// File: src/cts_angle.sv
// Angle pipeline: elapsed*rate + start angle, reduction mod 2pi, wrap to [-pi, pi).
module cts_angle (
  input  logic                             clk,
  input  logic                             ce,
  input  cts_pkg::cfg_t                    cfg,
  input  logic signed [31:0]               t_in,
  output logic signed [cts_pkg::ANG_W-1:0] ang,
  output logic signed [cts_pkg::ANG_W-1:0] yaw_half
);

  localparam int REM_W = 54;
  localparam logic [REM_W-1:0] MOD_OFFSET =
    REM_W'(cts_pkg::TWO_PI_Q32) << (cts_pkg::MOD_STEPS - 1);
  localparam logic signed [cts_pkg::ANG_W-1:0] PI_A     = cts_pkg::ANG_W'(cts_pkg::PI_Q32);
  localparam logic signed [cts_pkg::ANG_W-1:0] TWO_PI_A = cts_pkg::ANG_W'(cts_pkg::TWO_PI_Q32);

  logic signed [51:0]      prod_r;
  logic signed [52:0]      sum;
  logic [REM_W-1:0]        rem0_nxt;
  logic [REM_W-1:0]        rem_r [cts_pkg::MOD_STEPS+1];
  logic signed [cts_pkg::ANG_W-1:0] r_s;
  logic signed [cts_pkg::ANG_W-1:0] ang_r, yaw_r;

  always_ff @(posedge clk) begin
    if (ce) prod_r <= t_in * cfg.angular_rate;
  end

  // negative sums get a multiple of 2pi added so the reduction below is unsigned
  assign sum      = 53'(prod_r) + (53'(cfg.start_angle) <<< 16);
  assign rem0_nxt = sum[52] ? ($unsigned(54'(sum)) + MOD_OFFSET) : $unsigned(54'(sum));

  always_ff @(posedge clk) begin
    if (ce) rem_r[0] <= rem0_nxt;
  end

  for (genvar gj = 0; gj < cts_pkg::MOD_STEPS; gj++) begin : g_mod
    localparam logic [REM_W-1:0] SUB =
      REM_W'(cts_pkg::TWO_PI_Q32) << (cts_pkg::MOD_STEPS - 1 - gj);
    always_ff @(posedge clk) begin
      if (ce) rem_r[gj+1] <= (rem_r[gj] >= SUB) ? rem_r[gj] - SUB : rem_r[gj];
    end
  end

  assign r_s = signed'({1'b0, rem_r[cts_pkg::MOD_STEPS][cts_pkg::ANG_W-2:0]});

  // yaw toward the center is the wrapped angle plus pi, which is r - pi either way
  always_ff @(posedge clk) begin
    if (ce) begin
      ang_r <= (r_s >= PI_A) ? r_s - TWO_PI_A : r_s;
      yaw_r <= (r_s - PI_A) >>> 1;
    end
  end

  assign ang      = ang_r;
  assign yaw_half = yaw_r;

endmodule

// File: src/cts_cordic.sv
// Pipelined rotation-mode CORDIC, one stage per iteration, with a fold by pi.
module cts_cordic #(
  parameter int N = cts_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             ce,
  input  logic signed [cts_pkg::ANG_W-1:0] z_in,
  output logic signed [cts_pkg::XY_W-1:0]  cos_out,
  output logic signed [cts_pkg::XY_W-1:0]  sin_out
);

  localparam int AW = cts_pkg::ANG_W;
  localparam int XW = cts_pkg::XY_W;
  localparam logic signed [AW-1:0] PI_C   = AW'(cts_pkg::PI_Q32);
  localparam logic signed [AW-1:0] HALF_C = AW'(cts_pkg::HALF_PI_Q32);
  localparam logic signed [XW-1:0] KINV   = XW'(cts_pkg::kinv_q30(N));

  logic signed [AW-1:0] zf_r;
  logic                 nf_r;
  logic signed [XW-1:0] x_r [N];
  logic signed [XW-1:0] y_r [N];
  logic signed [AW-1:0] z_r [N];
  logic                 neg_r [N];
  logic signed [XW-1:0] cos_r, sin_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      if (z_in > HALF_C) begin
        zf_r <= z_in - PI_C;
        nf_r <= 1'b1;
      end else if (z_in < -HALF_C) begin
        zf_r <= z_in + PI_C;
        nf_r <= 1'b1;
      end else begin
        zf_r <= z_in;
        nf_r <= 1'b0;
      end
    end
  end

  for (genvar gi = 0; gi < N; gi++) begin : g_iter
    localparam logic signed [AW-1:0] ATAN_I = AW'(cts_pkg::atan_q32(gi));
    logic signed [XW-1:0] xi, yi;
    logic signed [AW-1:0] zi;
    logic                 ni;
    if (gi == 0) begin : g_first
      assign xi = KINV;
      assign yi = '0;
      assign zi = zf_r;
      assign ni = nf_r;
    end else begin : g_rest
      assign xi = x_r[gi-1];
      assign yi = y_r[gi-1];
      assign zi = z_r[gi-1];
      assign ni = neg_r[gi-1];
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        neg_r[gi] <= ni;
        if (!zi[AW-1]) begin
          x_r[gi] <= xi - (yi >>> gi);
          y_r[gi] <= yi + (xi >>> gi);
          z_r[gi] <= zi - ATAN_I;
        end else begin
          x_r[gi] <= xi + (yi >>> gi);
          y_r[gi] <= yi - (xi >>> gi);
          z_r[gi] <= zi + ATAN_I;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cos_r <= neg_r[N-1] ? -x_r[N-1] : x_r[N-1];
      sin_r <= neg_r[N-1] ? -y_r[N-1] : y_r[N-1];
    end
  end

  assign cos_out = cos_r;
  assign sin_out = sin_r;

endmodule

// File: src/cts_pose.sv
// Position scaling by radius with saturation, and quaternion formatting.
module cts_pose (
  input  logic                            clk,
  input  logic                            ce,
  input  cts_pkg::cfg_t                   cfg,
  input  logic signed [cts_pkg::XY_W-1:0] cos_p,
  input  logic signed [cts_pkg::XY_W-1:0] sin_p,
  input  logic signed [cts_pkg::XY_W-1:0] cos_h,
  input  logic signed [cts_pkg::XY_W-1:0] sin_h,
  output cts_pkg::pose_t                  pose
);

  localparam int XW = cts_pkg::XY_W;
  localparam int MW = XW + 32;

  function automatic logic signed [15:0] to_q15(input logic signed [XW-1:0] v);
    logic signed [XW:0] r;
    logic signed [19:0] q;
    r = (XW+1)'(v) + (XW+1)'(16384);
    q = 20'(r >>> 15);
    if (q > 20'sd32767) return 16'sd32767;
    else if (q < -20'sd32768) return -16'sd32768;
    else return q[15:0];
  endfunction

  function automatic logic signed [31:0] place(input logic signed [31:0] c,
                                               input logic signed [MW-1:0] m);
    logic signed [MW-1:0] rnd;
    logic signed [37:0]   s;
    rnd = (m + (MW'(1) <<< 29)) >>> 30;
    s = 38'(c) + 38'(rnd);
    if (s > 38'sd2147483647) return 32'sh7FFF_FFFF;
    else if (s < -38'sd2147483648) return 32'sh8000_0000;
    else return s[31:0];
  endfunction

  logic signed [31:0]   rad_s;
  logic signed [MW-1:0] mx_r, my_r;
  logic signed [15:0]   qw_r, qz_r;
  logic                 valid;
  logic                 face;
  cts_pkg::pose_t       pose_r;

  assign rad_s = signed'({1'b0, cfg.radius});
  assign valid = (cfg.duration != 32'd0) && (cfg.duration < cts_pkg::DUR_LIMIT);
  assign face  = (cfg.facing_mode == cts_pkg::FACE_CENTER) && (cfg.radius != '0);

  always_ff @(posedge clk) begin
    if (ce) begin
      mx_r <= rad_s * cos_p;
      my_r <= rad_s * sin_p;
      qw_r <= to_q15(cos_h);
      qz_r <= to_q15(sin_h);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pose_r.pose_valid <= valid;
      if (!valid) begin
        pose_r.pos_x  <= '0;
        pose_r.pos_y  <= '0;
        pose_r.pos_z  <= '0;
        pose_r.quat_w <= '0;
        pose_r.quat_z <= '0;
      end else begin
        pose_r.pos_x <= place(cfg.hub_x, mx_r);
        pose_r.pos_y <= place(cfg.hub_y, my_r);
        pose_r.pos_z <= cfg.hub_z;
        // fixed yaw, identity and unknown modes all give the unit quaternion
        pose_r.quat_w <= face ? qw_r : cts_pkg::Q15_ONE;
        pose_r.quat_z <= face ? qz_r : 16'sd0;
      end
    end
  end

  assign pose = pose_r;

endmodule

// File: src/cts_ctl.sv
// Pipeline valid line, finished tags, and the output register with a skid stage.
module cts_ctl #(
  parameter int DEPTH = 41
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_fin,
  input  cts_pkg::pose_t    pose_in,
  input  logic              out_stall,
  output logic              ce,
  output logic              in_stall,
  output logic              out_valid,
  output cts_pkg::result_t  out_res
);

  logic [DEPTH-1:0]  v_r, fin_r;
  logic              out_v_r, skid_v_r;
  logic              arrive, pop;
  cts_pkg::result_t  out_r, skid_r, item;

  // the whole pipe advances unless the skid stage is holding a request
  assign ce       = !skid_v_r;
  assign in_stall = skid_v_r;
  assign arrive   = ce && v_r[DEPTH-1];
  assign pop      = out_v_r && !out_stall;
  assign item     = '{pose: pose_in, finished: fin_r[DEPTH-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (ce) v_r <= {v_r[DEPTH-2:0], in_valid};
      if (!out_v_r || pop) begin
        if (skid_v_r) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= arrive;
        end
      end else if (arrive) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) fin_r <= {fin_r[DEPTH-2:0], in_fin};
    if (!out_v_r || pop) out_r <= skid_v_r ? skid_r : item;
    else if (arrive) skid_r <= item;
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a request while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_stall) |=> (out_v_r && !skid_v_r))
    else $error("skid did not move to the output register");

  a_blocked_arrival: assert property (@(posedge clk) disable iff (!rst_n)
    (arrive && out_v_r && out_stall) |=> skid_v_r)
    else $error("request arriving at a held output was not caught in the skid");

endmodule

// File: src/circular_trajectory_setpoint_top.sv
// Top level of the circular trajectory setpoint generator.
// A request passes through 21 angle reduction stages, CORDIC_STAGES + 2 CORDIC stages,
//   2 pose stages and the output register; the mod-2pi chain is fully pipelined.
// Throughput: one request per cycle while in_stall is low; both CORDICs are fully pipelined.
// in_stall rises only when the output is held and its skid stage is full.
// Reset (rst_n low, synchronous) clears all valid bits and the configuration registers to zero.
module circular_trajectory_setpoint_top #(
  parameter int CORDIC_STAGES = cts_pkg::CORDIC_STAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [31:0]         in_elapsed_time,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_pose_valid,
  output logic signed [31:0]         out_pos_x,
  output logic signed [31:0]         out_pos_y,
  output logic signed [31:0]         out_pos_z,
  output logic signed [15:0]         out_quat_w,
  output logic signed [15:0]         out_quat_x,
  output logic signed [15:0]         out_quat_y,
  output logic signed [15:0]         out_quat_z,
  output logic                       out_finished,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cts_pkg::ADDR_W-1:0] paddr,
  input  logic [cts_pkg::DATA_W-1:0] pwdata,
  output logic [cts_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int DEPTH = cts_pkg::ANG_STAGES + CORDIC_STAGES + 2 + cts_pkg::POSE_STAGES;

  cts_pkg::cfg_t    cfg;
  cts_pkg::pose_t   pose;
  cts_pkg::result_t res;
  logic             ce;
  logic             fin;
  logic signed [cts_pkg::ANG_W-1:0] ang, yaw_half;
  logic signed [cts_pkg::XY_W-1:0]  cos_p, sin_p, cos_h, sin_h;

  // elapsed time is signed, duration unsigned: compare on 33 bits
  assign fin = signed'({in_elapsed_time[31], in_elapsed_time}) >= signed'({1'b0, cfg.duration});

  cts_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cts_angle u_angle (
    .clk      (clk),
    .ce       (ce),
    .cfg      (cfg),
    .t_in     (in_elapsed_time),
    .ang      (ang),
    .yaw_half (yaw_half)
  );

  cts_cordic #(.N(CORDIC_STAGES)) u_cordic_pos (
    .clk     (clk),
    .ce      (ce),
    .z_in    (ang),
    .cos_out (cos_p),
    .sin_out (sin_p)
  );

  cts_cordic #(.N(CORDIC_STAGES)) u_cordic_yaw (
    .clk     (clk),
    .ce      (ce),
    .z_in    (yaw_half),
    .cos_out (cos_h),
    .sin_out (sin_h)
  );

  cts_pose u_pose (
    .clk   (clk),
    .ce    (ce),
    .cfg   (cfg),
    .cos_p (cos_p),
    .sin_p (sin_p),
    .cos_h (cos_h),
    .sin_h (sin_h),
    .pose  (pose)
  );

  cts_ctl #(.DEPTH(DEPTH)) u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_fin    (fin),
    .pose_in   (pose),
    .out_stall (out_stall),
    .ce        (ce),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_pose_valid = res.pose.pose_valid;
  assign out_pos_x      = res.pose.pos_x;
  assign out_pos_y      = res.pose.pos_y;
  assign out_pos_z      = res.pose.pos_z;
  assign out_quat_w     = res.pose.quat_w;
  assign out_quat_x     = '0;
  assign out_quat_y     = '0;
  assign out_quat_z     = res.pose.quat_z;
  assign out_finished   = res.finished;

endmodule

// File: bench/circular_trajectory_setpoint_top_test.sv
// Testbench for the circular trajectory setpoint generator: self-predicting, randomized.
module circular_trajectory_setpoint_top_test;

  localparam int STAGES       = cts_pkg::CORDIC_STAGES_DEF;
  localparam int LATENCY      = STAGES + 25;
  localparam int IDLE_LIMIT   = 4000;
  localparam longint SAT_LO   = -64'sd2147483648;
  localparam longint SAT_HI   = 64'sd2147483647;
  localparam logic [30:0] RADIUS_MAX = 31'h7FFF_FFFF;

  typedef struct {
    logic              pose_valid;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_z;
    logic              finished;
  } setpoint_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_elapsed_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_pose_valid, out_finished;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [cts_pkg::ADDR_W-1:0] paddr = '0;
  logic [cts_pkg::DATA_W-1:0] pwdata = '0;
  logic [cts_pkg::DATA_W-1:0] prdata;
  logic pready;

  circular_trajectory_setpoint_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_elapsed_time(in_elapsed_time),
    .out_valid(out_valid), .out_stall(out_stall), .out_pose_valid(out_pose_valid),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_quat_w(out_quat_w), .out_quat_x(out_quat_x), .out_quat_y(out_quat_y),
    .out_quat_z(out_quat_z), .out_finished(out_finished),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial forever #10 clk = ~clk;

  // shadow of the register file
  cts_pkg::cfg_t shadow;
  longint atan_tab [32];
  longint pi_q, kinv_q;

  setpoint_t pending_q[$];
  int  fail_count = 0;
  bit  idle_on = 1'b1;
  int  quiet_cycles = 0;

  // ---------------- predictor ----------------
  function automatic longint atan_inv_pow2(int i);
    longint unsigned acc = 0;
    int k = 0;
    int e;
    forever begin
      e = 62 - i * (2 * k + 1);
      if (e < 0) break;
      if (k % 2) acc -= (64'd1 << e) / longint'(2 * k + 1);
      else acc += (64'd1 << e) / longint'(2 * k + 1);
      k++;
    end
    return longint'(acc);
  endfunction

  function automatic longint atan_one_third();
    longint unsigned acc = 0, den = 3;
    int k = 0;
    forever begin
      if (k % 2) acc -= ((64'd1 << 62) / den) / longint'(2 * k + 1);
      else acc += ((64'd1 << 62) / den) / longint'(2 * k + 1);
      k++;
      if (den > 64'hFFFF_FFFF_FFFF_FFFF / 9) break;
      den *= 9;
    end
    return longint'(acc);
  endfunction

  // floor square root by bisection
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned lo = 0, hi = 64'd1 << 32, mid;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= v) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  task automatic prepare_tables();
    longint unsigned quarter;
    longint unsigned g2;
    quarter = atan_inv_pow2(1) + atan_one_third();
    atan_tab[0] = longint'((quarter + (64'd1 << 29)) >> 30);
    for (int i = 1; i < 32; i++)
      atan_tab[i] = (atan_inv_pow2(i) + (64'sd1 <<< 29)) >>> 30;
    // pi in Q.62 needs the full unsigned range
    pi_q = longint'((64'd4 * quarter + (64'd1 << 29)) >> 30);
    g2 = 64'd1 << 60;
    for (int i = 0; i < STAGES; i++) g2 += g2 >> (2 * i);
    kinv_q = longint'((64'd1 << 60) / floor_sqrt(g2));
  endtask

  function automatic void rotate(input longint ang, output longint cv, output longint sv);
    longint xv, yv, zv, dx, dy;
    bit flip;
    xv = kinv_q; yv = 0; zv = ang; flip = 1'b0;
    if (zv > pi_q / 2) begin zv -= pi_q; flip = 1'b1; end
    else if (zv < -(pi_q / 2)) begin zv += pi_q; flip = 1'b1; end
    for (int i = 0; i < STAGES; i++) begin
      dx = yv >>> i; dy = xv >>> i;
      if (zv >= 0) begin xv -= dx; yv += dy; zv -= atan_tab[i]; end
      else begin xv += dx; yv -= dy; zv += atan_tab[i]; end
    end
    cv = flip ? -xv : xv;
    sv = flip ? -yv : yv;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint half_to_q15(longint v);
    return clamp((v + 16384) >>> 15, -32768, 32767);
  endfunction

  function automatic setpoint_t predict_setpoint(logic signed [31:0] t_in);
    setpoint_t r;
    longint t, ang, c, s, yaw, hc, hs, rad;
    t = t_in;
    rad = longint'(shadow.radius);
    r.pose_valid = (shadow.duration != 0) && (shadow.duration < cts_pkg::DUR_LIMIT);
    r.finished = t >= longint'(shadow.duration);
    r.pos_x = 0; r.pos_y = 0; r.pos_z = 0; r.quat_w = 0; r.quat_z = 0;
    if (r.pose_valid) begin
      ang = t * longint'(shadow.angular_rate) + longint'(shadow.start_angle) * 65536;
      ang = ang % (2 * pi_q);
      if (ang < 0) ang += 2 * pi_q;
      if (ang >= pi_q) ang -= 2 * pi_q;
      rotate(ang, c, s);
      r.pos_x = clamp(longint'(shadow.hub_x) + ((rad * c + (64'sd1 <<< 29)) >>> 30),
                      SAT_LO, SAT_HI);
      r.pos_y = clamp(longint'(shadow.hub_y) + ((rad * s + (64'sd1 <<< 29)) >>> 30),
                      SAT_LO, SAT_HI);
      r.pos_z = shadow.hub_z;
      r.quat_w = cts_pkg::Q15_ONE;
      if (shadow.facing_mode == cts_pkg::FACE_CENTER && rad != 0) begin
        yaw = (ang >= 0) ? ang - pi_q : ang + pi_q;
        rotate(yaw >>> 1, hc, hs);
        r.quat_w = half_to_q15(hc);
        r.quat_z = half_to_q15(hs);
      end
    end
    return r;
  endfunction

  // ---------------- drivers ----------------
  task automatic write_reg(input cts_pkg::reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= cts_pkg::ADDR_W'(4 * int'(idx)); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      cts_pkg::REG_HUB_X:        shadow.hub_x = val;
      cts_pkg::REG_HUB_Y:        shadow.hub_y = val;
      cts_pkg::REG_HUB_Z:        shadow.hub_z = val;
      cts_pkg::REG_RADIUS:       shadow.radius = val[30:0];
      cts_pkg::REG_START_ANGLE:  shadow.start_angle = val[19:0];
      cts_pkg::REG_ANGULAR_RATE: shadow.angular_rate = val[19:0];
      cts_pkg::REG_DURATION:     shadow.duration = val;
      cts_pkg::REG_FACING_MODE:  shadow.facing_mode = val[1:0];
      default: ;
    endcase
  endtask

  task automatic send_time(input logic signed [31:0] t);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_elapsed_time <= t;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(predict_setpoint(t));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // idle window before register writes
  task automatic settle();
    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // ---------------- result checking ----------------
  task automatic compare(input string fld, input longint want, input longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fld, want, got);
    end
  endtask

  int stall_left = 0;
  always @(posedge clk) begin
    setpoint_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result: expected none, actual pos_x %0d", $time, out_pos_x);
      end else begin
        e = pending_q.pop_front();
        compare("pose_valid", e.pose_valid, out_pose_valid);
        compare("pos_x", e.pos_x, out_pos_x);
        compare("pos_y", e.pos_y, out_pos_y);
        compare("pos_z", e.pos_z, out_pos_z);
        compare("quat_w", e.quat_w, out_quat_w);
        compare("quat_x", 0, out_quat_x);
        compare("quat_y", 0, out_quat_y);
        compare("quat_z", e.quat_z, out_quat_z);
        compare("finished", e.finished, out_finished);
      end
    end
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 11);
    out_stall <= (stall_left > 0);
  end

  // watchdog: cycles without any accepted request, result or APB select
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_reset_duration();
    // duration 0 after reset: pose invalid, finished still computed
    send_time(32'sd0);
    send_time(32'sh7FFF_FFFF);
    send_time(-32'sh8000_0000);
    send_time(-32'sd1);
    settle();
  endtask

  task automatic test_directed();
    write_reg(cts_pkg::REG_HUB_X, 32'h7FFF_0000);
    write_reg(cts_pkg::REG_HUB_Y, 32'h8000_0000);
    write_reg(cts_pkg::REG_HUB_Z, 32'h0001_8000);
    write_reg(cts_pkg::REG_RADIUS, RADIUS_MAX);
    write_reg(cts_pkg::REG_START_ANGLE, 32'h0007_FFFF);
    write_reg(cts_pkg::REG_ANGULAR_RATE, 32'hFFF8_0000);
    write_reg(cts_pkg::REG_DURATION, 32'd65535999);
    write_reg(cts_pkg::REG_FACING_MODE, cts_pkg::FACE_CENTER);
    send_time(32'sd0);
    send_time(32'sd65535999);
    send_time(32'sd65535998);
    send_time(32'sh7FFF_FFFF);
    send_time(-32'sh8000_0000);
    settle();
    // zero radius while facing center gives yaw zero
    write_reg(cts_pkg::REG_RADIUS, 32'd0);
    send_time(32'sd65536);
    settle();
    write_reg(cts_pkg::REG_RADIUS, 32'h0001_0000);
    write_reg(cts_pkg::REG_FACING_MODE, cts_pkg::FACE_FIXED);
    send_time(32'sd12345);
    settle();
    write_reg(cts_pkg::REG_FACING_MODE, cts_pkg::FACE_IDENTITY);
    send_time(32'sd12345);
    settle();
    write_reg(cts_pkg::REG_FACING_MODE, 32'd3);
    send_time(32'sd12345);
    settle();
    // duration at the upper limit is invalid
    write_reg(cts_pkg::REG_DURATION, 32'd65536000);
    send_time(32'sd1);
    settle();
    write_reg(cts_pkg::REG_DURATION, 32'hFFFF_FFFF);
    send_time(32'sh7FFF_FFFF);
    settle();
    write_reg(cts_pkg::REG_DURATION, 32'd1);
    write_reg(cts_pkg::REG_FACING_MODE, cts_pkg::FACE_CENTER);
    send_time(32'sd0);
    send_time(32'sd1);
    settle();
  endtask

  function automatic logic [31:0] pick_duration();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd65536000;
      2: return $urandom;
      3: return 32'd1;
      4: return 32'd65535999;
      default: return $urandom_range(1, 65535999);
    endcase
  endfunction

  task automatic test_random(input int phases, input int per_phase);
    logic signed [31:0] t;
    for (int p = 0; p < phases; p++) begin
      write_reg(cts_pkg::REG_HUB_X, ($urandom_range(0, 3) == 0) ? $urandom :
                                    $urandom_range(0, 1 << 22) - (1 << 21));
      write_reg(cts_pkg::REG_HUB_Y, ($urandom_range(0, 3) == 0) ? $urandom :
                                    $urandom_range(0, 1 << 22) - (1 << 21));
      write_reg(cts_pkg::REG_HUB_Z, $urandom);
      write_reg(cts_pkg::REG_RADIUS, ($urandom_range(0, 7) == 0) ? 32'd0 :
                ($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 21)));
      write_reg(cts_pkg::REG_START_ANGLE, $urandom);
      write_reg(cts_pkg::REG_ANGULAR_RATE, $urandom);
      write_reg(cts_pkg::REG_DURATION, pick_duration());
      write_reg(cts_pkg::REG_FACING_MODE, $urandom_range(0, 3));
      for (int n = 0; n < per_phase; n++) begin
        case ($urandom_range(0, 3))
          0: t = $urandom;
          1: t = shadow.duration + $urandom_range(0, 4) - 2;
          default: t = $urandom_range(0, 65536 * 1000);
        endcase
        send_time(t);
        // sender hold-off until the pipeline is empty
        if (n == per_phase / 2 && p % 3 == 0) wait_drained();
      end
      settle();
    end
  endtask

  initial begin
    shadow = '0;
    prepare_tables();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_duration();
    test_directed();
    test_random(6, 200);
    idle_on = 1'b0;
    test_random(1, 170);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
src/cts_pkg.sv
src/cts_regs.sv
src/cts_angle.sv
src/cts_cordic.sv
src/cts_pose.sv
src/cts_ctl.sv
src/circular_trajectory_setpoint_top.sv
bench/circular_trajectory_setpoint_top_test.sv
